@@ sv/rpbc_pkg.sv @@
package rpbc_pkg;

    // Fixed field widths
    localparam int CoordW   = 32;
    localparam int DistW    = 31;
    localparam int GroupW   = 6;
    localparam int DiffW    = CoordW + 1;
    localparam int ProdW    = CoordW + DiffW;
    localparam int FracW    = 16;
    localparam int CfgIdxW  = 3;
    localparam int MaxGroups = 64;
    localparam int NumAxes  = 3;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_BOX_MAX_Z = 3'd5;

    // Ray request
    typedef struct packed {
        logic signed [CoordW-1:0] origin_x;
        logic signed [CoordW-1:0] origin_y;
        logic signed [CoordW-1:0] origin_z;
        logic signed [CoordW-1:0] inv_dir_x;
        logic signed [CoordW-1:0] inv_dir_y;
        logic signed [CoordW-1:0] inv_dir_z;
        logic [DistW-1:0]         max_distance;
        logic [GroupW-1:0]        group_index;
        logic                     is_last;
    } t_in_req;

    // Packet result
    typedef struct packed {
        logic              any_hit;
        logic [GroupW-1:0] first_hit_group;
        logic [GroupW-1:0] last_hit_group;
    } t_out_req;

    // Box corners, index 0..2 = x, y, z
    typedef struct packed {
        logic [NumAxes-1:0][CoordW-1:0] lo;
        logic [NumAxes-1:0][CoordW-1:0] hi;
    } t_box;

    // Per-ray data that travels beside the slab pipeline
    typedef struct packed {
        logic [DistW-1:0]  reach;
        logic [GroupW-1:0] group;
        logic              last;
    } t_side;

    // Round Q33.32 product to Q16.16 (half up, floor) and saturate
    function automatic logic signed [CoordW-1:0] round_sat(input logic signed [ProdW-1:0] p);
        logic signed [ProdW-1:0]       q;
        logic [ProdW-FracW-1:0]        r;
        logic [ProdW-FracW-CoordW:0]   top;
        q   = p + ProdW'(1 << (FracW - 1));
        r   = q[ProdW-1:FracW];
        top = r[ProdW-FracW-1:CoordW-1];
        if ((top == '0) || (top == '1)) begin
            round_sat = r[CoordW-1:0];
        end else if (r[ProdW-FracW-1]) begin
            round_sat = {1'b1, {(CoordW-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(CoordW-1){1'b1}}};
        end
    endfunction

endpackage

@@ sv/rpbc_axis.sv @@
// One slab axis: difference, product, round/saturate, ordering
module rpbc_axis (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [rpbc_pkg::CoordW-1:0]    i_origin,
    input  logic signed [rpbc_pkg::CoordW-1:0]    i_inv_dir,
    input  logic signed [rpbc_pkg::CoordW-1:0]    i_box_lo,
    input  logic signed [rpbc_pkg::CoordW-1:0]    i_box_hi,
    output logic signed [rpbc_pkg::CoordW-1:0]    o_lo,
    output logic signed [rpbc_pkg::CoordW-1:0]    o_hi
);

    logic signed [rpbc_pkg::DiffW-1:0]  r_d_lo, r_d_hi;
    logic signed [rpbc_pkg::CoordW-1:0] r_inv;
    logic signed [rpbc_pkg::ProdW-1:0]  r_p_lo, r_p_hi;
    logic signed [rpbc_pkg::CoordW-1:0] r_t_lo, r_t_hi;
    logic signed [rpbc_pkg::CoordW-1:0] r_lo, r_hi;

    // Exact corner - origin differences (33 bits)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_lo <= rpbc_pkg::DiffW'(i_box_lo) - rpbc_pkg::DiffW'(i_origin);
            r_d_hi <= rpbc_pkg::DiffW'(i_box_hi) - rpbc_pkg::DiffW'(i_origin);
            r_inv  <= i_inv_dir;
        end
    end

    // Slab distance products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo <= rpbc_pkg::ProdW'(r_inv) * rpbc_pkg::ProdW'(r_d_lo);
            r_p_hi <= rpbc_pkg::ProdW'(r_inv) * rpbc_pkg::ProdW'(r_d_hi);
        end
    end

    // Back to Q16.16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_lo <= rpbc_pkg::round_sat(r_p_lo);
            r_t_hi <= rpbc_pkg::round_sat(r_p_hi);
        end
    end

    // Near/far ordering per slab
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= (r_t_lo < r_t_hi) ? r_t_lo : r_t_hi;
            r_hi <= (r_t_lo < r_t_hi) ? r_t_hi : r_t_lo;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

@@ sv/rpbc_slab.sv @@
// Slab test pipeline: three axes, sideband, entry/exit and hit decision
module rpbc_slab (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  rpbc_pkg::t_in_req      i_ray,
    input  rpbc_pkg::t_box         i_box,
    output logic                   o_valid,
    output logic                   o_hit,
    output rpbc_pkg::t_side        o_side
);

    localparam int Stages = 5;

    logic signed [rpbc_pkg::CoordW-1:0] w_org [rpbc_pkg::NumAxes];
    logic signed [rpbc_pkg::CoordW-1:0] w_inv [rpbc_pkg::NumAxes];
    logic signed [rpbc_pkg::CoordW-1:0] w_lo  [rpbc_pkg::NumAxes];
    logic signed [rpbc_pkg::CoordW-1:0] w_hi  [rpbc_pkg::NumAxes];

    logic [Stages-1:0]      r_v;
    rpbc_pkg::t_side        r_side [Stages];
    rpbc_pkg::t_side        w_side_in;
    logic                   r_hit;

    logic signed [rpbc_pkg::CoordW-1:0] w_entry, w_exit, w_e01, w_x01;
    logic signed [rpbc_pkg::CoordW:0]   w_dist, w_exit_w, w_lim;
    logic                               w_hit;

    assign w_org[0] = i_ray.origin_x;
    assign w_org[1] = i_ray.origin_y;
    assign w_org[2] = i_ray.origin_z;
    assign w_inv[0] = i_ray.inv_dir_x;
    assign w_inv[1] = i_ray.inv_dir_y;
    assign w_inv[2] = i_ray.inv_dir_z;

    for (genvar k = 0; k < rpbc_pkg::NumAxes; k++) begin : g_axis
        rpbc_axis u_axis (
            .i_clk     (i_clk),
            .i_en      (i_en),
            .i_origin  (w_org[k]),
            .i_inv_dir (w_inv[k]),
            .i_box_lo  ($signed(i_box.lo[k])),
            .i_box_hi  ($signed(i_box.hi[k])),
            .o_lo      (w_lo[k]),
            .o_hi      (w_hi[k])
        );
    end

    // Clamp group index to the group count
    always_comb begin
        w_side_in.reach = i_ray.max_distance;
        w_side_in.last  = i_ray.is_last;
        if (int'(i_ray.group_index) > rpbc_pkg::MaxGroups - 1) begin
            w_side_in.group = rpbc_pkg::GroupW'(rpbc_pkg::MaxGroups - 1);
        end else begin
            w_side_in.group = i_ray.group_index;
        end
    end

    // Valid bits and sideband alongside the axis stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Stages-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= w_side_in;
            for (int s = 1; s < Stages; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Entry = max of near values, exit = min of far values; hit if exit >= 0 and entry <= min(exit, reach)
    always_comb begin
        w_e01    = (w_lo[0] > w_lo[1]) ? w_lo[0] : w_lo[1];
        w_entry  = (w_e01 > w_lo[2]) ? w_e01 : w_lo[2];
        w_x01    = (w_hi[0] < w_hi[1]) ? w_hi[0] : w_hi[1];
        w_exit   = (w_x01 < w_hi[2]) ? w_x01 : w_hi[2];
        w_dist   = $signed({2'b00, r_side[Stages-2].reach});
        w_exit_w = (rpbc_pkg::CoordW+1)'(w_exit);
        w_lim    = (w_exit_w < w_dist) ? w_exit_w : w_dist;
        w_hit    = !w_exit[rpbc_pkg::CoordW-1] &&
                   ((rpbc_pkg::CoordW+1)'(w_entry) <= w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= w_hit;
        end
    end

    assign o_valid = r_v[Stages-1];
    assign o_hit   = r_hit;
    assign o_side  = r_side[Stages-1];

endmodule

@@ sv/rpbc_accum.sv @@
// Packet bookkeeping and result register
module rpbc_accum (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_hit,
    input  rpbc_pkg::t_side       i_side,
    output logic                  o_valid,
    output rpbc_pkg::t_out_req    o_out
);

    logic                        r_started, n_started;
    logic                        r_hit_seen, n_hit_seen;
    logic [rpbc_pkg::GroupW-1:0] r_first, n_first;
    logic [rpbc_pkg::GroupW-1:0] r_low, n_low;
    logic [rpbc_pkg::GroupW-1:0] r_high, n_high;
    logic                        r_out_valid, n_out_valid;
    rpbc_pkg::t_out_req          r_out, n_out;
    logic                        w_hs;

    // Next packet state for the ray leaving the slab pipeline
    always_comb begin
        n_started   = r_started;
        n_hit_seen  = r_hit_seen;
        n_first     = r_first;
        n_low       = r_low;
        n_high      = r_high;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_hs        = r_started && r_hit_seen;
        if (i_valid) begin
            if (!r_started) begin
                n_first = i_side.group;
            end
            if (i_hit) begin
                n_low  = (!w_hs || (i_side.group < r_low))  ? i_side.group : r_low;
                n_high = (!w_hs || (i_side.group > r_high)) ? i_side.group : r_high;
            end
            n_hit_seen = w_hs || i_hit;
            n_started  = 1'b1;
            if (i_side.last) begin
                n_out_valid           = 1'b1;
                n_out.any_hit         = n_hit_seen;
                n_out.first_hit_group = n_hit_seen ? n_low : n_first;
                n_out.last_hit_group  = n_hit_seen ? n_high : i_side.group;
                n_started             = 1'b0;
                n_hit_seen            = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_hit_seen  <= 1'b0;
            r_first     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_started   <= n_started;
            r_hit_seen  <= n_hit_seen;
            r_first     <= n_first;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

@@ sv/ray_packet_box_cull.sv @@
// Channel  Direction  Handshake                Payload
// ray      in         i_in_valid / o_in_ready   i_in  (rpbc_pkg::t_in_req)
// result   out        o_out_valid / i_out_ready o_out (rpbc_pkg::t_out_req)
// config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One ray per cycle unless a result stalls; after its last ray a packet's result
// passes the 5-stage slab pipeline (diff, multiply, round, order, hit) and
// the result register. Reset is synchronous, active low, and clears valid bits
// and packet state. A stalled result freezes the whole pipeline, which then
// holds o_in_ready low. Config writes are always taken.
module ray_packet_box_cull (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  rpbc_pkg::t_in_req                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output rpbc_pkg::t_out_req                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rpbc_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [rpbc_pkg::CoordW-1:0]       i_cfg_data
);

    rpbc_pkg::t_box   r_box;
    rpbc_pkg::t_side  w_side;
    logic             w_en, w_slab_valid, w_hit;

    // Pipeline advances unless a finished result is waiting
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpbc_pkg::REG_BOX_MIN_X: r_box.lo[0] <= i_cfg_data;
                rpbc_pkg::REG_BOX_MIN_Y: r_box.lo[1] <= i_cfg_data;
                rpbc_pkg::REG_BOX_MIN_Z: r_box.lo[2] <= i_cfg_data;
                rpbc_pkg::REG_BOX_MAX_X: r_box.hi[0] <= i_cfg_data;
                rpbc_pkg::REG_BOX_MAX_Y: r_box.hi[1] <= i_cfg_data;
                rpbc_pkg::REG_BOX_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rpbc_slab u_slab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_ray   (i_in),
        .i_box   (r_box),
        .o_valid (w_slab_valid),
        .o_hit   (w_hit),
        .o_side  (w_side)
    );

    rpbc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_slab_valid),
        .i_hit   (w_hit),
        .i_side  (w_side),
        .o_valid (o_out_valid),
        .o_out   (o_out)
    );

    // A hit result never reports an inverted group range
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.any_hit) |->
            (o_out.first_hit_group <= o_out.last_hit_group))
        else $error("hit range inverted");

    // A waiting result blocks new rays
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("ray taken while result stalled");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule
